/* rtl/ndr_pkg.sv */
// Shared types, codes and defaults for the N-dimensional descriptor ring.
package ndr_pkg;

  localparam int RING_DEPTH_DEF = 256;
  localparam int MAX_DIMS_DEF   = 4;
  localparam int CNT_W          = 60;
  localparam int PEND_W         = 48;

  localparam logic [2:0] FN_RESERVE = 3'd0;
  localparam logic [2:0] FN_WRITE   = 3'd1;
  localparam logic [2:0] FN_COMMIT  = 3'd2;
  localparam logic [2:0] FN_ADVANCE = 3'd3;
  localparam logic [2:0] FN_QUERY   = 3'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  dim_count;
    logic [2:0]  word_index;
    logic [63:0] word_value;
    logic [1:0]  dim_sel;
    logic [47:0] count_value;
  } in_word_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  cur_dims;
    logic [63:0] offset;
    logic [59:0] remaining_count;
    logic [63:0] dim_stride;
    logic [47:0] pend_bytes;
  } out_word_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_RESV,
    OP_WRITE,
    OP_COMMIT,
    OP_CAP_W0,
    OP_CAP_W1,
    OP_MUL_FAC,
    OP_FAC_DONE,
    OP_R_DIM,
    OP_ADV_UPD,
    OP_CARRY,
    OP_R_LVL,
    OP_ADD_POS0,
    OP_MUL_POS,
    OP_SUM_DONE,
    OP_Q_REM,
    OP_Q_STR,
    OP_PUSH
  } dp_op_t;

  typedef enum logic [2:0] {
    RD_W0,
    RD_W1,
    RD_FAC,
    RD_DIM,
    RD_STR,
    RD_LVL,
    RD_SUMSTR
  } rd_sel_t;

  typedef struct packed {
    dp_op_t  op;
    logic    rd_en;
    rd_sel_t rd_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       dsel_bad;
    logic       dsel_zero;
    logic       fac_done;
    logic       i_zero;
    logic       sum_done;
    logic       adv_full;
    logic       carry_eq;
    logic       lvl_ge_act;
    logic       mul_done;
  } dp_stat_t;

endpackage

/* rtl/ndr_mul.sv */
// Iterative 64x64 multiplier, product modulo 2^64, four bits of b per cycle.
module ndr_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] prod,
  output logic        done
);
  localparam int DIG   = 4;
  localparam int STEPS = 64 / DIG;
  localparam int CW    = $clog2(STEPS);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [63:0]   a_r;
  logic [63:0]   b_r;
  logic [63:0]   acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + a_r * 64'(b_r[DIG-1:0]);
      a_r   <= a_r << DIG;
      b_r   <= b_r >> DIG;
    end
  end

  assign prod = acc_r;
  assign done = done_r;
endmodule

/* rtl/ndr_datapath.sv */
// Ring storage, pointers, per-dimension progress and arithmetic for the descriptor ring.
module ndr_datapath #(
  parameter int RING_DEPTH = ndr_pkg::RING_DEPTH_DEF,
  parameter int MAX_DIMS   = ndr_pkg::MAX_DIMS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ndr_pkg::in_word_t   in_data,
  input  ndr_pkg::ctrl_cmd_t  cmd,
  output ndr_pkg::dp_stat_t   stat,
  output ndr_pkg::out_word_t  out_data
);
  import ndr_pkg::*;

  localparam int A_W   = $clog2(RING_DEPTH);
  localparam int PTR_W = A_W + 1;
  localparam int LVL_W = $clog2(MAX_DIMS + 1);
  localparam int K_W   = $clog2(2 * MAX_DIMS + 1);
  localparam int CMP_W = (LVL_W > 2) ? LVL_W + 1 : 3;
  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(RING_DEPTH);

  // ring memory
  logic [63:0] mem [RING_DEPTH];
  logic [63:0] mem_q;
  logic        wr_en;
  logic [A_W-1:0] wa, ra;

  // control state
  logic [PTR_W-1:0]  wp_r, wp_nxt, rp_r, rp_nxt, wrap_r, wrap_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic              pflag_r, pflag_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [CNT_W-1:0]  pos_r [MAX_DIMS];
  logic [CNT_W-1:0]  pos_nxt [MAX_DIMS];

  // working registers
  in_word_t          item_r, item_nxt;
  logic [LVL_W-1:0]  act_r, act_nxt, i_r, i_nxt;
  logic [CNT_W-1:0]  cnt0_r, cnt0_nxt, r_r, r_nxt, rem_r, rem_nxt;
  logic [63:0]       bytes_r, bytes_nxt, ofs_r, ofs_nxt, stride_r, stride_nxt;
  logic              acc_r, acc_nxt;
  logic [2:0]        cdims_r, cdims_nxt;
  out_word_t         out_r, out_nxt;

  // multiplier
  logic        mul_start, mul_done;
  logic [63:0] mul_a, mul_b, mul_p;

  ndr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_p),
    .done  (mul_done)
  );

  function automatic logic [CNT_W-1:0] pos_at(input logic [CMP_W-1:0] idx);
    logic [CNT_W-1:0] v;
    v = '0;
    for (int k = 0; k < MAX_DIMS; k++) begin
      if (idx == CMP_W'(k)) v = pos_r[k];
    end
    return v;
  endfunction

  logic [CMP_W-1:0] dsel_c, act_c, lvl_c, i_c;
  assign dsel_c = CMP_W'(item_r.dim_sel);
  assign act_c  = CMP_W'(act_r);
  assign lvl_c  = CMP_W'(lvl_r);
  assign i_c    = CMP_W'(i_r);

  logic adv_full, carry_eq;
  assign adv_full = !pflag_r && (dsel_c == act_c - 1'b1) &&
                    (CNT_W'(item_r.count_value) == r_r);
  assign carry_eq = (pos_at(lvl_c) == r_r);

  // read address: head pointer plus word offset, wrapped once
  logic [K_W-1:0]   rk;
  logic [PTR_W-1:0] rsum, wsum;
  always_comb begin
    case (cmd.rd_sel)
      RD_W0:     rk = '0;
      RD_W1:     rk = K_W'(1);
      RD_FAC:    rk = K_W'({i_r, 1'b0});
      RD_DIM:    rk = K_W'({item_r.dim_sel, 1'b0});
      RD_STR:    rk = K_W'({item_r.dim_sel, 1'b1});
      RD_LVL:    rk = K_W'({lvl_r, 1'b0});
      RD_SUMSTR: rk = K_W'({i_r, 1'b1});
      default:   rk = '0;
    endcase
    rsum = rp_r + PTR_W'(rk);
    ra   = (rsum >= DEPTH_P) ? A_W'(rsum - DEPTH_P) : A_W'(rsum);
    wsum = wp_r + PTR_W'(item_r.word_index);
    wa   = (wsum >= DEPTH_P) ? A_W'(wsum - DEPTH_P) : A_W'(wsum);
  end

  assign wr_en = (cmd.op == OP_WRITE);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wa] <= item_r.word_value;
    if (cmd.rd_en) mem_q <= mem[ra];
  end

  // reserve / commit helpers
  logic [3:0]       dims_cl;
  logic [PTR_W-1:0] need, nwp, step2act;
  logic [LVL_W-1:0] act_new, lvl_inc;
  logic [PEND_W:0]  pend_add;
  always_comb begin
    dims_cl  = (int'(item_r.dim_count) > MAX_DIMS) ? 4'(MAX_DIMS) : 4'(item_r.dim_count);
    need     = PTR_W'({dims_cl, 1'b0});
    nwp      = wp_r + need;
    step2act = PTR_W'({act_r, 1'b0});
    act_new  = (int'(mem_q[3:0]) > MAX_DIMS) ? LVL_W'(MAX_DIMS) : LVL_W'(mem_q[3:0]);
    lvl_inc  = lvl_r + 1'b1;
    pend_add = {1'b0, pend_r} + {1'b0, item_r.count_value};
  end

  always_comb begin
    logic [CNT_W-1:0] base;
    wp_nxt = wp_r; rp_nxt = rp_r; wrap_nxt = wrap_r; pend_nxt = pend_r;
    pflag_nxt = pflag_r; lvl_nxt = lvl_r;
    for (int k = 0; k < MAX_DIMS; k++) pos_nxt[k] = pos_r[k];
    item_nxt = item_r; act_nxt = act_r; i_nxt = i_r; cnt0_nxt = cnt0_r; r_nxt = r_r;
    rem_nxt = rem_r; bytes_nxt = bytes_r; ofs_nxt = ofs_r; stride_nxt = stride_r;
    acc_nxt = acc_r; cdims_nxt = cdims_r; out_nxt = out_r;
    mul_start = 1'b0; mul_a = bytes_r; mul_b = mem_q;
    base = item_r.dim_sel == 2'd0 ? cnt0_r : mem_q[CNT_W-1:0];

    case (cmd.op)
      OP_LOAD: begin
        item_nxt  = in_data;
        bytes_nxt = 64'(in_data.count_value);
        acc_nxt = 1'b0; cdims_nxt = '0; ofs_nxt = '0; rem_nxt = '0; stride_nxt = '0;
        if ((in_data.func inside {FN_ADVANCE, FN_QUERY}) &&
            (rp_r >= DEPTH_P || rp_r >= wrap_r)) begin
          rp_nxt   = '0;
          wrap_nxt = DEPTH_P;
        end
      end
      OP_RESV: begin
        if (nwp > DEPTH_P) begin
          if (!(rp_r <= need || wp_r < rp_r)) begin
            wrap_nxt = wp_r;
            wp_nxt   = '0;
            acc_nxt  = 1'b1;
          end
        end else if (!((wp_r < rp_r && nwp >= rp_r) || (nwp == DEPTH_P && rp_r == '0))) begin
          acc_nxt = 1'b1;
        end
      end
      OP_COMMIT: begin
        wp_nxt   = (nwp >= DEPTH_P) ? '0 : nwp;
        pend_nxt = pend_add[PEND_W] ? {PEND_W{1'b1}} : pend_add[PEND_W-1:0];
      end
      OP_CAP_W0: begin
        act_nxt  = act_new;
        cnt0_nxt = mem_q[63:4];
        i_nxt    = '0;
      end
      OP_CAP_W1: begin
        ofs_nxt   = mem_q;
        i_nxt     = lvl_r;
        cdims_nxt = pflag_r ? 3'(lvl_inc) : 3'(act_r);
      end
      OP_MUL_FAC: begin
        mul_start = 1'b1;
        mul_a     = bytes_r;
        mul_b     = (i_r == '0) ? 64'(cnt0_r) : mem_q;
      end
      OP_FAC_DONE: begin
        bytes_nxt = mul_p;
        i_nxt     = i_r + 1'b1;
      end
      OP_R_DIM: r_nxt = base;
      OP_R_LVL: r_nxt = mem_q[CNT_W-1:0];
      OP_ADV_UPD: begin
        pend_nxt = (64'(pend_r) >= bytes_r) ? pend_r - bytes_r[PEND_W-1:0] : '0;
        if (adv_full) begin
          rp_nxt = rp_r + step2act;
        end else begin
          pflag_nxt = 1'b1;
          lvl_nxt   = LVL_W'(item_r.dim_sel);
          for (int k = 0; k < MAX_DIMS; k++) begin
            if (dsel_c == CMP_W'(k)) begin
              pos_nxt[k] = pflag_r ? pos_r[k] + CNT_W'(item_r.count_value)
                                   : CNT_W'(item_r.count_value);
            end
          end
        end
      end
      OP_CARRY: begin
        lvl_nxt = lvl_inc;
        if (CMP_W'(lvl_inc) >= act_c) begin
          pflag_nxt = 1'b0;
          rp_nxt    = rp_r + step2act;
        end
        for (int k = 0; k < MAX_DIMS; k++) begin
          if (lvl_c == CMP_W'(k)) pos_nxt[k] = '0;
          if (CMP_W'(lvl_inc) == CMP_W'(k) && CMP_W'(lvl_inc) < act_c)
            pos_nxt[k] = pos_r[k] + 1'b1;
        end
      end
      OP_ADD_POS0: begin
        ofs_nxt = ofs_r + 64'(pos_at('0));
        i_nxt   = i_r + 1'b1;
      end
      OP_MUL_POS: begin
        mul_start = 1'b1;
        mul_a     = 64'(pos_at(i_c));
        mul_b     = mem_q;
      end
      OP_SUM_DONE: begin
        ofs_nxt = ofs_r + mul_p;
        i_nxt   = i_r + 1'b1;
      end
      OP_Q_REM: begin
        rem_nxt = base;
        if (pflag_r) begin
          if (dsel_c > lvl_c) rem_nxt = CNT_W'(1);
          else if (dsel_c == lvl_c) rem_nxt = base - pos_at(dsel_c);
        end
      end
      OP_Q_STR: stride_nxt = mem_q;
      OP_PUSH: begin
        out_nxt.accepted        = acc_r;
        out_nxt.cur_dims        = cdims_r;
        out_nxt.offset          = ofs_r;
        out_nxt.remaining_count = rem_r;
        out_nxt.dim_stride      = stride_r;
        out_nxt.pend_bytes      = pend_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      wrap_r  <= DEPTH_P;
      pend_r  <= '0;
      pflag_r <= 1'b0;
      lvl_r   <= '0;
      for (int k = 0; k < MAX_DIMS; k++) pos_r[k] <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      wrap_r  <= wrap_nxt;
      pend_r  <= pend_nxt;
      pflag_r <= pflag_nxt;
      lvl_r   <= lvl_nxt;
      for (int k = 0; k < MAX_DIMS; k++) pos_r[k] <= pos_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    item_r   <= item_nxt;
    act_r    <= act_nxt;
    i_r      <= i_nxt;
    cnt0_r   <= cnt0_nxt;
    r_r      <= r_nxt;
    rem_r    <= rem_nxt;
    bytes_r  <= bytes_nxt;
    ofs_r    <= ofs_nxt;
    stride_r <= stride_nxt;
    acc_r    <= acc_nxt;
    cdims_r  <= cdims_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    stat.func       = item_r.func;
    stat.dsel_bad   = dsel_c >= act_c;
    stat.dsel_zero  = item_r.dim_sel == 2'd0;
    stat.fac_done   = i_c >= dsel_c;
    stat.i_zero     = i_r == '0;
    stat.sum_done   = !pflag_r || (i_c >= act_c);
    stat.adv_full   = adv_full;
    stat.carry_eq   = carry_eq;
    stat.lvl_ge_act = lvl_c >= act_c;
    stat.mul_done   = mul_done;
  end

  assign out_data = out_r;
endmodule

/* rtl/ndr_ctrl.sv */
// Sequencer for the descriptor ring: walks each operation through the datapath.
module ndr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ndr_pkg::dp_stat_t  stat,
  output ndr_pkg::ctrl_cmd_t cmd
);
  import ndr_pkg::*;

  typedef enum logic [21:0] {
    S_IDLE   = 22'd1 << 0,
    S_DISP   = 22'd1 << 1,
    S_A_W0   = 22'd1 << 2,
    S_A_CHKD = 22'd1 << 3,
    S_A_FAC  = 22'd1 << 4,
    S_A_FACW = 22'd1 << 5,
    S_A_MUL  = 22'd1 << 6,
    S_A_RDR  = 22'd1 << 7,
    S_A_RW   = 22'd1 << 8,
    S_A_UPD  = 22'd1 << 9,
    S_A_CHK  = 22'd1 << 10,
    S_A_CNX  = 22'd1 << 11,
    S_A_CRW  = 22'd1 << 12,
    S_Q_W0   = 22'd1 << 13,
    S_Q_W1   = 22'd1 << 14,
    S_Q_SUM  = 22'd1 << 15,
    S_Q_SW   = 22'd1 << 16,
    S_Q_SM   = 22'd1 << 17,
    S_Q_REM  = 22'd1 << 18,
    S_Q_RW   = 22'd1 << 19,
    S_Q_SW2  = 22'd1 << 20,
    S_FIN    = 22'd1 << 21
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = OP_NOP;
    cmd.rd_en     = 1'b0;
    cmd.rd_sel    = RD_W0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_FIN;
        case (stat.func)
          FN_RESERVE: cmd.op = OP_RESV;
          FN_WRITE:   cmd.op = OP_WRITE;
          FN_COMMIT:  cmd.op = OP_COMMIT;
          FN_ADVANCE: begin
            cmd.rd_en = 1'b1; cmd.rd_sel = RD_W0; state_nxt = S_A_W0;
          end
          FN_QUERY: begin
            cmd.rd_en = 1'b1; cmd.rd_sel = RD_W0; state_nxt = S_Q_W0;
          end
          default: ;
        endcase
      end
      S_A_W0: begin
        cmd.op = OP_CAP_W0; state_nxt = S_A_CHKD;
      end
      S_A_CHKD: state_nxt = stat.dsel_bad ? S_FIN : S_A_FAC;
      S_A_FAC: begin
        if (stat.fac_done) state_nxt = S_A_RDR;
        else if (stat.i_zero) begin
          cmd.op = OP_MUL_FAC; state_nxt = S_A_MUL;
        end else begin
          cmd.rd_en = 1'b1; cmd.rd_sel = RD_FAC; state_nxt = S_A_FACW;
        end
      end
      S_A_FACW: begin
        cmd.op = OP_MUL_FAC; state_nxt = S_A_MUL;
      end
      S_A_MUL: begin
        if (stat.mul_done) begin
          cmd.op = OP_FAC_DONE; state_nxt = S_A_FAC;
        end
      end
      S_A_RDR: begin
        if (stat.dsel_zero) begin
          cmd.op = OP_R_DIM; state_nxt = S_A_UPD;
        end else begin
          cmd.rd_en = 1'b1; cmd.rd_sel = RD_DIM; state_nxt = S_A_RW;
        end
      end
      S_A_RW: begin
        cmd.op = OP_R_DIM; state_nxt = S_A_UPD;
      end
      S_A_UPD: begin
        cmd.op    = OP_ADV_UPD;
        state_nxt = stat.adv_full ? S_FIN : S_A_CHK;
      end
      S_A_CHK: begin
        if (stat.carry_eq) begin
          cmd.op = OP_CARRY; state_nxt = S_A_CNX;
        end else state_nxt = S_FIN;
      end
      S_A_CNX: begin
        if (stat.lvl_ge_act) state_nxt = S_FIN;
        else begin
          cmd.rd_en = 1'b1; cmd.rd_sel = RD_LVL; state_nxt = S_A_CRW;
        end
      end
      S_A_CRW: begin
        cmd.op = OP_R_LVL; state_nxt = S_A_CHK;
      end
      S_Q_W0: begin
        cmd.op = OP_CAP_W0; cmd.rd_en = 1'b1; cmd.rd_sel = RD_W1; state_nxt = S_Q_W1;
      end
      S_Q_W1: begin
        cmd.op = OP_CAP_W1; state_nxt = S_Q_SUM;
      end
      S_Q_SUM: begin
        if (stat.sum_done) state_nxt = S_Q_REM;
        else if (stat.i_zero) cmd.op = OP_ADD_POS0;
        else begin
          cmd.rd_en = 1'b1; cmd.rd_sel = RD_SUMSTR; state_nxt = S_Q_SW;
        end
      end
      S_Q_SW: begin
        cmd.op = OP_MUL_POS; state_nxt = S_Q_SM;
      end
      S_Q_SM: begin
        if (stat.mul_done) begin
          cmd.op = OP_SUM_DONE; state_nxt = S_Q_SUM;
        end
      end
      S_Q_REM: begin
        if (stat.dsel_bad) state_nxt = S_FIN;
        else if (stat.dsel_zero) begin
          cmd.op = OP_Q_REM; state_nxt = S_FIN;
        end else begin
          cmd.rd_en = 1'b1; cmd.rd_sel = RD_DIM; state_nxt = S_Q_RW;
        end
      end
      S_Q_RW: begin
        cmd.op = OP_Q_REM; cmd.rd_en = 1'b1; cmd.rd_sel = RD_STR; state_nxt = S_Q_SW2;
      end
      S_Q_SW2: begin
        cmd.op = OP_Q_STR; state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_PUSH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
endmodule

/* rtl/nd_transfer_descriptor_ring_top.sv */
// Top level of the N-dimensional transfer descriptor ring.
// Usage:
//  - in_valid/in_ready carry one command word (reserve, write, commit,
//    advance, query); every command returns exactly one result word on
//    out_valid/out_ready, in order.
//  - Reserve, write, commit and undefined commands pass through the
//    dispatch and finish states to the result register; the next word
//    is taken once the controller is back in idle.
//  - Advance and query read the head descriptor at most one ring word per
//    cycle (single read port, registered data) and use a shared iterative
//    multiplier of 16 steps per product. Advance in dimension d needs one
//    product per lower dimension plus a ring read per carry level; query
//    needs one product per partially consumed higher dimension.
//  - One command is in flight at a time; the next is taken once the
//    current result is in the output register, so a result waiting for
//    the receiver does not block the next command's work, only its finish.
//  - If the receiver stalls, the result stays stable with out_valid high.
//  - Reset (rst_n low, synchronous) empties the ring pointers, clears the
//    pending byte total and progress; ring words are undefined until written.
module nd_transfer_descriptor_ring_top #(
  parameter int RING_DEPTH = ndr_pkg::RING_DEPTH_DEF,
  parameter int MAX_DIMS   = ndr_pkg::MAX_DIMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ndr_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ndr_pkg::out_word_t out_data
);
  import ndr_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ndr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ndr_datapath #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_DIMS   (MAX_DIMS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );
endmodule
